@@ rtl/core/sat_pkg.sv @@
// Shared types and codes for the segment address translation core.
`default_nettype none

package sat_pkg;

    // Operation codes carried in the op field of an input transfer
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_V2F  = 2'd1;
    localparam logic [1:0] OP_F2V  = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    // Default table depth
    localparam int MAX_SEGMENTS_DEF = 16;

    // Width of the segment count register
    localparam int SEG_COUNT_W = 5;

    // Input transfer payload
    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  entry_index;
        logic [63:0] seg_vaddr;
        logic [63:0] seg_file_offset;
        logic [63:0] seg_size;
        logic [63:0] query_value;
    } t_in_item;

    // Result transfer payload
    typedef struct packed {
        logic [63:0] translated;
        logic        hit;
    } t_out_item;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch query value and direction
        logic load_wr;   // write the table entry of the input transfer
        logic rd_en;     // read the table entry at the scan index
        logic rd_last;   // this read is the last entry to search
        logic res_load;  // load the result register and flush the scan pipe
        logic res_hit;   // result is a hit
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic vld;       // a compared entry is at the end of the scan pipe
        logic last;      // that entry was the last one searched
        logic hit;       // that entry contains the query value
    } t_dp_stat;

endpackage

`default_nettype wire

@@ rtl/core/segment_address_translate_core.sv @@
// Top level of the segment address translation core.
`default_nettype none

// Segment table translating virtual addresses to file offsets and back.
// A load transfer (op 0) writes one table entry in the cycle it is accepted
// and returns no result; op 3 is ignored. A query transfer (op 1 or 2) scans
// entries 0 .. n-1 in order, n = min(segment count, MAX_SEGMENTS), through a
// one-read-per-cycle table memory and a two-stage compare pipe. The result
// strobe follows the first hit or, on a miss, the last compared entry, and
// comes from a miss state when n is zero; busy is high until the strobe
// cycle, so the next start may be taken in that cycle. The result is marked
// valid for the single strobe cycle only; the receiver must capture it then.
module segment_address_translate_core #(
    parameter int MAX_SEGMENTS = sat_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output      logic                            busy,
    input  wire sat_pkg::t_in_item               i_item,
    input  wire logic                            i_cfg_we,
    input  wire logic [sat_pkg::SEG_COUNT_W-1:0] i_cfg_wdata,
    output      logic                            o_result_valid,
    output      sat_pkg::t_out_item              o_result
);
    import sat_pkg::*;

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [IDX_W-1:0] rd_idx;

    sat_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_item.op),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_stat         (stat),
        .o_cmd          (cmd),
        .o_rd_idx       (rd_idx),
        .o_result_valid (o_result_valid)
    );

    sat_dpath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .IDX_W        (IDX_W)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .i_rd_idx (rd_idx),
        .o_stat   (stat),
        .o_result (o_result)
    );

`ifndef NO_ASSERTIONS
    // Each result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // A miss reports zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.hit) |-> (o_result.translated == 64'd0))
        else $error("miss with nonzero translation");

    // An accepted query keeps the core busy
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_item.op == OP_V2F) || (i_item.op == OP_F2V)))
        |=> busy)
        else $error("query accepted without going busy");

    // A result only ends a busy period
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without a query in flight");
`endif

endmodule

`default_nettype wire

@@ rtl/core/sat_ctrl.sv @@
// Controller: segment count register, scan sequencer and result strobe.
`default_nettype none

module sat_ctrl #(
    parameter int MAX_SEGMENTS = sat_pkg::MAX_SEGMENTS_DEF,
    parameter int IDX_W        = 4,
    parameter int CNT_W        = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic [1:0]                    i_op,
    input  wire logic                          i_cfg_we,
    input  wire logic [sat_pkg::SEG_COUNT_W-1:0] i_cfg_wdata,
    input  wire sat_pkg::t_dp_stat             i_stat,
    output      sat_pkg::t_dp_cmd              o_cmd,
    output      logic [IDX_W-1:0]              o_rd_idx,
    output      logic                          o_result_valid
);
    import sat_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_MISS
    } t_state;

    t_state                 r_state, n_state;
    logic [SEG_COUNT_W-1:0] r_seg_count, n_seg_count;
    logic [CNT_W-1:0]       r_num, n_num;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_result_valid, n_result_valid;

    logic             accept;
    logic             is_query;
    logic             last_idx;
    logic [CNT_W-1:0] num_lim;
    t_dp_cmd          cmd;

    // Clamp the search length to the table depth
    always_comb begin
        if (32'(r_seg_count) > 32'(MAX_SEGMENTS)) begin
            num_lim = CNT_W'(MAX_SEGMENTS);
        end else begin
            num_lim = CNT_W'(r_seg_count);
        end
    end

    assign accept   = start && (r_state == S_IDLE);
    assign is_query = (i_op == OP_V2F) || (i_op == OP_F2V);
    assign last_idx = (32'(r_idx) + 32'd1) == 32'(r_num);

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        n_seg_count    = r_seg_count;
        n_num          = r_num;
        n_idx          = r_idx;
        n_result_valid = 1'b0;
        cmd            = '0;
        cmd.capture    = accept && is_query;
        cmd.load_wr    = accept && (i_op == OP_LOAD);
        cmd.rd_last    = last_idx;

        if (i_cfg_we) begin
            n_seg_count = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (accept && is_query) begin
                    n_num = num_lim;
                    n_idx = '0;
                    if (num_lim == '0) begin
                        n_state = S_MISS;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN, S_DRAIN: begin
                // Finish on the first hit in index order, or after the last entry
                if (i_stat.vld && (i_stat.hit || i_stat.last)) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_hit    = i_stat.hit;
                    n_result_valid = 1'b1;
                    n_state        = S_IDLE;
                end else if (r_state == S_SCAN) begin
                    // Issue the next table read
                    cmd.rd_en = 1'b1;
                    if (last_idx) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_MISS: begin
                cmd.res_load   = 1'b1;
                cmd.res_hit    = 1'b0;
                n_result_valid = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_seg_count    <= '0;
            r_num          <= '0;
            r_idx          <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_seg_count    <= n_seg_count;
            r_num          <= n_num;
            r_idx          <= n_idx;
            r_result_valid <= n_result_valid;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cmd          = cmd;
    assign o_rd_idx       = r_idx;
    assign o_result_valid = r_result_valid;

endmodule

`default_nettype wire

@@ rtl/core/sat_dpath.sv @@
// Datapath: segment table memory, range compare pipe and result register.
`default_nettype none

module sat_dpath #(
    parameter int MAX_SEGMENTS = sat_pkg::MAX_SEGMENTS_DEF,
    parameter int IDX_W        = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sat_pkg::t_in_item  i_item,
    input  wire sat_pkg::t_dp_cmd   i_cmd,
    input  wire logic [IDX_W-1:0]   i_rd_idx,
    output      sat_pkg::t_dp_stat  o_stat,
    output      sat_pkg::t_out_item o_result
);
    import sat_pkg::*;

    typedef struct packed {
        logic [63:0] virt_base;
        logic [63:0] file_base;
        logic [63:0] span;
    } t_entry;

    t_entry      r_mem [MAX_SEGMENTS];
    t_entry      r_rd;
    logic [63:0] r_value;
    logic        r_from_virt;
    logic        r_s1_vld, r_s1_last;
    logic        r_s2_vld, r_s2_last;
    logic [64:0] r_diff;
    logic [63:0] r_span;
    logic [63:0] r_dst;
    t_out_item   r_result;

    logic        wr_ok;
    logic [63:0] src;
    logic [63:0] dst;
    logic        hit;
    logic [63:0] sum;

    assign wr_ok = 32'(i_item.entry_index) < 32'(MAX_SEGMENTS);

    // Table write on a load transfer; registered read during the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && wr_ok) begin
            r_mem[IDX_W'(i_item.entry_index)] <= '{
                virt_base: i_item.seg_vaddr,
                file_base: i_item.seg_file_offset,
                span:      i_item.seg_size
            };
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_rd_idx];
        end
    end

    // Latch the query
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_value     <= i_item.query_value;
            r_from_virt <= (i_item.op == OP_V2F);
        end
    end

    // Pick source and destination bases by direction
    assign src = r_from_virt ? r_rd.virt_base : r_rd.file_base;
    assign dst = r_from_virt ? r_rd.file_base : r_rd.virt_base;

    // Offset into the segment with borrow
    always_ff @(posedge i_clk) begin
        r_diff <= {1'b0, r_value} - {1'b0, src};
        r_span <= r_rd.span;
        r_dst  <= dst;
    end

    // Advance the scan pipe valid tags; drop them when the result loads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.res_load) begin
            r_s1_vld  <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s2_last <= 1'b0;
        end else begin
            r_s1_vld  <= i_cmd.rd_en;
            r_s1_last <= i_cmd.rd_last;
            r_s2_vld  <= r_s1_vld;
            r_s2_last <= r_s1_last;
        end
    end

    // Containment: base <= value and value - base < span
    assign hit = r_s2_vld && !r_diff[64] && (r_diff[63:0] < r_span);
    assign sum = r_diff[63:0] + r_dst;

    assign o_stat = '{vld: r_s2_vld, last: r_s2_last, hit: hit};

    // Result register, zero on a miss
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_result.translated <= i_cmd.res_hit ? sum : 64'd0;
            r_result.hit        <= i_cmd.res_hit;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the segment address translation core.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sat_pkg::*;

    localparam int TABLE_DEPTH   = MAX_SEGMENTS_DEF;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int STALL_LIMIT   = 1000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    t_in_item               i_item;
    logic                   i_cfg_we;
    logic [SEG_COUNT_W-1:0] i_cfg_wdata;
    logic                   o_result_valid;
    t_out_item              o_result;

    // Shadow copy of the segment table and the count register
    logic [63:0]            seg_virt [TABLE_DEPTH];
    logic [63:0]            seg_file [TABLE_DEPTH];
    logic [63:0]            seg_span [TABLE_DEPTH];
    logic [SEG_COUNT_W-1:0] seg_count;

    t_out_item pending_translations[$];
    int        error_count;
    int        idle_pct;
    int        stall_cycles;

    segment_address_translate_core #(
        .MAX_SEGMENTS(TABLE_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // Free-running 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Walk the active entries in order; the first one containing the value wins
    function automatic t_out_item predict_translation(logic [1:0] op, logic [63:0] value);
        t_out_item   res;
        int          n;
        logic [63:0] src;
        logic [63:0] dst;
        res.translated = '0;
        res.hit        = 1'b0;
        n = (seg_count > TABLE_DEPTH) ? TABLE_DEPTH : seg_count;
        for (int i = 0; i < n; i++) begin
            src = (op == OP_V2F) ? seg_virt[i] : seg_file[i];
            dst = (op == OP_V2F) ? seg_file[i] : seg_virt[i];
            if (value >= src && (value - src) < seg_span[i]) begin
                res.translated = value - src + dst;
                res.hit        = 1'b1;
                return res;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Present one item, hold it until the core takes it, then update the shadow state
    task automatic send_item(input t_in_item item);
        bit held;
        held = 1'b0;
        while ($urandom_range(99) < idle_pct) begin
            if (!held) start <= 1'b0;
            held = 1'b1;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= item;
        do @(posedge i_clk); while (busy);
        case (item.op)
            OP_LOAD: begin
                seg_virt[item.entry_index] = item.seg_vaddr;
                seg_file[item.entry_index] = item.seg_file_offset;
                seg_span[item.entry_index] = item.seg_size;
            end
            OP_V2F, OP_F2V: pending_translations.push_back(
                predict_translation(item.op, item.query_value));
            default: ;
        endcase
    endtask

    // Drop start, drain all results, let any load settle, then write the count
    task automatic write_segment_count(input int value);
        start <= 1'b0;
        while (pending_translations.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[SEG_COUNT_W-1:0];
        @(posedge i_clk);
        seg_count = value[SEG_COUNT_W-1:0];
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_entry(input int idx, input logic [63:0] vaddr,
                              input logic [63:0] offset, input logic [63:0] size);
        t_in_item item;
        item.op              = OP_LOAD;
        item.entry_index     = idx[3:0];
        item.seg_vaddr       = vaddr;
        item.seg_file_offset = offset;
        item.seg_size        = size;
        item.query_value     = rand64();
        send_item(item);
    endtask

    task automatic query(input logic [1:0] op, input logic [63:0] value);
        t_in_item item;
        item.op              = op;
        item.entry_index     = 4'($urandom_range(15));
        item.seg_vaddr       = rand64();
        item.seg_file_offset = rand64();
        item.seg_size        = rand64();
        item.query_value     = value;
        send_item(item);
    endtask

    // Count zero after reset: every query misses, reserved op is dropped
    task automatic test_empty_table();
        query(OP_V2F, 64'd0);
        query(OP_F2V, '1);
        query(OP_RSVD, '1);
    endtask

    // Fill every entry: overlap, zero size, ranges that end past 2^64, catch-all
    task automatic test_table_fill();
        load_entry(0, 64'h0000_0000_0040_0000, 64'h0, 64'h1000);
        load_entry(1, 64'h0000_0000_0040_0800, 64'h8000, 64'h1000);
        load_entry(2, 64'h0000_0000_0050_0000, 64'h2000, 64'h0);
        load_entry(3, 64'hFFFF_FFFF_FFFF_FF00, 64'h1_0000, 64'h1000);
        load_entry(4, 64'h0, 64'hFFFF_FFFF_FFFF_FFF0, 64'h100);
        for (int i = 5; i < TABLE_DEPTH - 1; i++)
            load_entry(i, rand64(), rand64(), 64'(i) << 12);
        load_entry(TABLE_DEPTH - 1, 64'h0, 64'h0, '1);
    endtask

    // Full table: first match wins, edges of ranges, wrapped results
    task automatic test_first_match();
        write_segment_count(TABLE_DEPTH);
        query(OP_V2F, 64'h0000_0000_0040_0010);
        query(OP_V2F, 64'h0000_0000_0040_0900);
        query(OP_V2F, 64'h0000_0000_0040_1500);
        query(OP_V2F, 64'h0000_0000_0050_0000);
        query(OP_V2F, '1);
        query(OP_V2F, 64'h20);
        query(OP_F2V, 64'hFFFF_FFFF_FFFF_FFF8);
    endtask

    // Count past the table saturates; a count of one searches entry 0 only
    task automatic test_count_limits();
        write_segment_count((1 << SEG_COUNT_W) - 1);
        query(OP_F2V, 64'h0000_0000_0000_0FFF);
        write_segment_count(1);
        query(OP_V2F, 64'h0000_0000_0040_0FFF);
        query(OP_V2F, 64'h0000_0000_0040_1000);
    endtask

    function automatic logic [63:0] pick_base();
        case ($urandom_range(3))
            0:       return rand64();
            1:       return ~64'd0 - 64'($urandom_range(4096));
            2:       return 64'($urandom_range(65535));
            default: return rand64() & ~64'hFFF;
        endcase
    endfunction

    function automatic logic [63:0] pick_span();
        case ($urandom_range(5))
            0:       return 64'd0;
            1:       return 64'($urandom_range(1, 4096));
            2:       return rand64();
            3:       return '1;
            4:       return 64'd1 << $urandom_range(63);
            default: return rand64() >> $urandom_range(63);
        endcase
    endfunction

    // Query value aimed at an active entry, mostly at or near its range edges
    function automatic logic [63:0] pick_query(input logic [1:0] op);
        int          n;
        int          k;
        logic [63:0] src;
        logic [63:0] sp;
        n = (seg_count > TABLE_DEPTH) ? TABLE_DEPTH : seg_count;
        if (n == 0 || $urandom_range(99) < 20) return rand64();
        k   = $urandom_range(n - 1);
        src = (op == OP_V2F) ? seg_virt[k] : seg_file[k];
        sp  = seg_span[k];
        case ($urandom_range(4))
            0:       return src;
            1:       return src + sp - 64'd1;
            2:       return src + sp;
            3:       return src - 64'd1;
            default: return (sp == 0) ? src : src + (rand64() % sp);
        endcase
    endfunction

    // Mixed loads, queries and reserved ops over several count settings
    task automatic test_random_traffic(input int idle, input int first_count);
        t_in_item item;
        int       r;
        idle_pct = idle;
        for (int chunk = 0; chunk < 3; chunk++) begin
            write_segment_count((chunk == 0) ? first_count : $urandom_range(31));
            for (int j = 0; j < 50; j++) begin
                r = $urandom_range(99);
                item.entry_index     = 4'($urandom_range(15));
                item.seg_vaddr       = ($urandom_range(1)) ? pick_base() : rand64();
                item.seg_file_offset = ($urandom_range(1)) ? pick_base() : rand64();
                item.seg_size        = pick_span();
                if (r < 22)      item.op = OP_LOAD;
                else if (r < 26) item.op = OP_RSVD;
                else if (r < 63) item.op = OP_V2F;
                else             item.op = OP_F2V;
                item.query_value = (item.op == OP_LOAD || item.op == OP_RSVD) ?
                                   rand64() : pick_query(item.op);
                send_item(item);
            end
        end
    endtask

    // Compare each result strobe against the oldest expected translation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_result_valid) begin
            if (pending_translations.size() == 0) begin
                report_mismatch("unexpected result", o_result.translated, 64'd0);
            end else begin
                want = pending_translations.pop_front();
                if (o_result.translated !== want.translated)
                    report_mismatch("translated", o_result.translated, want.translated);
                if (o_result.hit !== want.hit)
                    report_mismatch("hit", 64'(o_result.hit), 64'(want.hit));
            end
        end
    end

    // End the run when nothing transfers for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        seg_count    = '0;
        error_count  = 0;
        idle_pct     = 0;
        stall_cycles = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            seg_virt[i] = '0;
            seg_file[i] = '0;
            seg_span[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 8;
        test_empty_table();
        test_table_fill();
        test_first_match();
        test_count_limits();
        test_random_traffic(8, TABLE_DEPTH);
        test_random_traffic(61, (1 << SEG_COUNT_W) - 1);
        test_random_traffic(0, 0);

        // Drain outstanding results and let the last item settle
        start <= 1'b0;
        while (pending_translations.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/sat_pkg.sv
rtl/core/sat_ctrl.sv
rtl/core/sat_dpath.sv
rtl/core/segment_address_translate_core.sv
sim/testbench.sv
